// ===== hdl/mhf_pkg.sv =====
// shared types, constants and the crc-32 octet step for the multicast hash filter
package mhf_pkg;

   localparam int MAC_WIDTH     = 48;
   localparam int BUCKET_WIDTH  = 6;
   localparam int BUCKET_COUNT  = 1 << BUCKET_WIDTH;
   localparam int CRC_WIDTH     = 32;
   localparam int BUCKET_LSB    = 23;
   localparam int OCTET_COUNT   = MAC_WIDTH / 8;

   localparam logic [CRC_WIDTH-1:0] CRC_POLY   = 32'h04C1_1DB7;
   localparam logic [CRC_WIDTH-1:0] CRC_PRESET = 32'hFFFF_FFFF;

   typedef enum logic {
      CMD_SUBSCRIBE   = 1'b0,
      CMD_UNSUBSCRIBE = 1'b1
   } mhf_cmd_type;

   typedef struct packed {
      mhf_cmd_type            command;
      logic [MAC_WIDTH-1:0]   mac_address;
   } mhf_req_type;

   typedef struct packed {
      logic [BUCKET_WIDTH-1:0] bucket;
      logic [BUCKET_COUNT-1:0] hash_table;
      logic                    ignored;
   } mhf_rsp_type;

   // per-bucket counter control
   typedef struct packed {
      logic update;
      logic unsubscribe;
   } mhf_cell_ctl_type;

   // per-bucket counter status
   typedef struct packed {
      logic nonzero_next;
      logic refused;
   } mhf_cell_sts_type;

   // one octet through the shift-left crc register, lsb of the octet first
   function automatic logic [CRC_WIDTH-1:0] crc_octet(
      input logic [CRC_WIDTH-1:0] crc_cur,
      input logic [7:0]           octet
   );
      logic [CRC_WIDTH-1:0] c;
      logic                 fb;
      c = crc_cur;
      for (int k = 0; k < 8; k++) begin
         fb = octet[k] ^ c[CRC_WIDTH-1];
         c  = {c[CRC_WIDTH-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
      end
      return c;
   endfunction

endpackage

// ===== hdl/mhf_crc_bucket.sv =====
// crc-32 xor network over the six address octets, gives the bucket index
module mhf_crc_bucket (
   input  logic [mhf_pkg::MAC_WIDTH-1:0]    mac_address,
   output logic [mhf_pkg::BUCKET_WIDTH-1:0] bucket
);

   logic [mhf_pkg::CRC_WIDTH-1:0] crc;

   always_comb begin
      crc = mhf_pkg::CRC_PRESET;
      // first transmitted octet sits in the top byte
      for (int b = 0; b < mhf_pkg::OCTET_COUNT; b++) begin
         crc = mhf_pkg::crc_octet(crc, mac_address[(mhf_pkg::MAC_WIDTH - 8 - 8*b) +: 8]);
      end
   end

   assign bucket = crc[mhf_pkg::BUCKET_LSB +: mhf_pkg::BUCKET_WIDTH];

endmodule

// ===== hdl/mhf_count_cell.sv =====
// one saturating reference counter of the bucket row
module mhf_count_cell #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  mhf_pkg::mhf_cell_ctl_type ctl,
   output mhf_pkg::mhf_cell_sts_type sts
);

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   at_max;
   logic                   at_zero;

   assign at_max  = (count_ff == {COUNT_WIDTH{1'b1}});
   assign at_zero = (count_ff == '0);

   always_comb begin
      count_in    = count_ff;
      sts.refused = 1'b0;
      if (ctl.update) begin
         if (ctl.unsubscribe) begin
            if (at_zero) sts.refused = 1'b1;
            else         count_in    = count_ff - 1'b1;
         end else begin
            if (at_max)  sts.refused = 1'b1;
            else         count_in    = count_ff + 1'b1;
         end
      end
      sts.nonzero_next = (count_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== hdl/multicast_hash_filter.sv =====
// top level of the reference-counted multicast hash filter
//
// Takes one subscribe or unsubscribe request word per cycle when not stalled,
// each with a 48-bit multicast address, and answers each with exactly one result
// word. The bucket is bits 28:23 of a crc-32 (poly 0x04c11db7, preset all ones,
// octets first transmitted first, each octet lsb first). A row of 64 saturating
// counters of COUNT_WIDTH bits, cleared by reset, tracks the subscribers of each
// bucket; the result carries the bucket, the 64-bit hash table after this request
// (bit i set while count i is nonzero) and an ignored flag for a subscribe at
// full count or an unsubscribe at zero. Throughput is one word per cycle while
// rsp_stall is low, set by the read-modify-write of the counter row. A request
// lands in the input register; when the result slot is free or draining it
// updates the counts and loads the result register in the same cycle. While a
// finished result waits on rsp_stall the empty input register takes one more
// word, then req_stall stays high until the result is taken.
module multicast_hash_filter #(
   parameter int COUNT_WIDTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  mhf_pkg::mhf_req_type req_word,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output mhf_pkg::mhf_rsp_type rsp_word
);

   // input register stage
   logic                 in_valid_ff;
   logic                 in_valid_in;
   mhf_pkg::mhf_req_type in_word_ff;

   // result register stage
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   mhf_pkg::mhf_rsp_type rsp_word_ff;
   mhf_pkg::mhf_rsp_type rsp_word_in;

   logic                               advance;
   logic                               req_take;
   logic [mhf_pkg::BUCKET_WIDTH-1:0]   bucket;
   logic [mhf_pkg::BUCKET_COUNT-1:0]   nonzero_next;
   logic [mhf_pkg::BUCKET_COUNT-1:0]   refused;

   // held word moves to the result register when that slot is free or draining
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   // stall only while the input register is full and cannot move on
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   // bucket hash from the registered address
   mhf_crc_bucket u_crc (
      .mac_address (in_word_ff.mac_address),
      .bucket      (bucket)
   );

   // counter row, each cell updates itself when its bucket is hit
   for (genvar i = 0; i < mhf_pkg::BUCKET_COUNT; i++) begin : g_cell
      mhf_pkg::mhf_cell_ctl_type cell_ctl;
      mhf_pkg::mhf_cell_sts_type cell_sts;

      assign cell_ctl.update      = advance &&
                                    (bucket == mhf_pkg::BUCKET_WIDTH'(i));
      assign cell_ctl.unsubscribe = (in_word_ff.command == mhf_pkg::CMD_UNSUBSCRIBE);

      mhf_count_cell #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (cell_ctl),
         .sts   (cell_sts)
      );

      assign nonzero_next[i] = cell_sts.nonzero_next;
      assign refused[i]      = cell_sts.refused;
   end

   // result word: the map already reflects this request
   always_comb begin
      rsp_word_in.bucket     = bucket;
      rsp_word_in.hash_table = nonzero_next;
      rsp_word_in.ignored    = |refused;
   end

   // handshake next state
   always_comb begin
      if (req_take)     in_valid_in = 1'b1;
      else if (advance) in_valid_in = 1'b0;
      else              in_valid_in = in_valid_ff;

      if (advance)                       rsp_valid_in = 1'b1;
      else if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      else                               rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_word_ff <= req_word;
      end
      if (advance) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

// ===== test/multicast_hash_filter_tb.sv =====
// self-checking testbench for the reference-counted multicast hash filter
`timescale 1ns / 100ps

module multicast_hash_filter_tb;

   localparam int COUNT_WIDTH = 8;
   localparam logic [COUNT_WIDTH-1:0] COUNT_FULL = '1;
   localparam logic [31:0] HASH_POLY   = 32'h04C1_1DB7;
   localparam logic [31:0] HASH_PRESET = 32'hFFFF_FFFF;
   localparam int CYCLE_LIMIT  = 200_000;
   localparam int REPORT_LIMIT = 10;
   // margin after the last result has drained
   localparam int TAIL_CYCLES  = 8;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   mhf_pkg::mhf_req_type req_word = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   mhf_pkg::mhf_rsp_type rsp_word;

   // predictor state: per-bucket subscriber counts and the resulting hash table
   logic [COUNT_WIDTH-1:0]           bucket_refs [mhf_pkg::BUCKET_COUNT];
   logic [mhf_pkg::BUCKET_COUNT-1:0] subscribed_map;
   mhf_pkg::mhf_rsp_type             predicted_results[$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count    = 0;

   // address pool so that buckets get hit again and again in random traffic
   logic [mhf_pkg::MAC_WIDTH-1:0] address_pool [24];

   multicast_hash_filter #(
      .COUNT_WIDTH(COUNT_WIDTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word (req_word),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word (rsp_word)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver backpressure, random per cycle at the current phase rate
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // crc-32, shift-left register, octets first transmitted first, lsb of each octet first
   function automatic logic [mhf_pkg::BUCKET_WIDTH-1:0] bucket_of_address(
      input logic [mhf_pkg::MAC_WIDTH-1:0] mac
   );
      logic [31:0] crc;
      logic        fb;
      crc = HASH_PRESET;
      for (int n = 0; n < 6; n++) begin
         for (int k = 0; k < 8; k++) begin
            fb  = mac[40 - 8 * n + k] ^ crc[31];
            crc = {crc[30:0], 1'b0} ^ (fb ? HASH_POLY : 32'h0);
         end
      end
      return crc[mhf_pkg::BUCKET_LSB +: mhf_pkg::BUCKET_WIDTH];
   endfunction

   // apply one request to the predicted counts and return the word it should produce
   function automatic mhf_pkg::mhf_rsp_type predict_filter_update(
      input mhf_pkg::mhf_req_type w
   );
      logic [mhf_pkg::BUCKET_WIDTH-1:0] b;
      logic [COUNT_WIDTH-1:0]           c;
      mhf_pkg::mhf_rsp_type             r;
      b = bucket_of_address(w.mac_address);
      c = bucket_refs[b];
      r.ignored = 1'b0;
      if (w.command == mhf_pkg::CMD_SUBSCRIBE) begin
         // saturated counter refuses another subscriber
         if (c == COUNT_FULL) r.ignored = 1'b1;
         else c = c + 1'b1;
      end else begin
         // nothing to drop from an empty bucket
         if (c == '0) r.ignored = 1'b1;
         else c = c - 1'b1;
      end
      bucket_refs[b]    = c;
      subscribed_map[b] = (c != '0);
      r.bucket     = b;
      r.hash_table = subscribed_map;
      return r;
   endfunction

   // result checker: sample before the edge, compare after it
   initial begin
      mhf_pkg::mhf_rsp_type got;
      mhf_pkg::mhf_rsp_type want;
      forever begin
         @(negedge clock);
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = rsp_word;
            @(posedge clock);
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("unexpected result word: bucket %0d table %h ignored %b",
                           got.bucket, got.hash_table, got.ignored);
            end else begin
               want = predicted_results.pop_front();
               if (got.bucket !== want.bucket || got.hash_table !== want.hash_table ||
                   got.ignored !== want.ignored) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display("mismatch: bucket %0d/%0d table %h/%h ignored %b/%b (exp/got)",
                              want.bucket, got.bucket, want.hash_table, got.hash_table,
                              want.ignored, got.ignored);
               end
            end
         end
      end
   end

   // send one request word; entered and left at a rising edge
   task automatic send_word(input mhf_pkg::mhf_cmd_type cmd,
                            input logic [mhf_pkg::MAC_WIDTH-1:0] mac);
      mhf_pkg::mhf_req_type w;
      bit                   accepted;
      w.command     = cmd;
      w.mac_address = mac;
      accepted      = 1'b0;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      while (!accepted) begin
         // stall is settled well before the next edge
         @(negedge clock);
         accepted = (req_stall === 1'b0);
         @(posedge clock);
      end
      predicted_results.push_back(predict_filter_update(w));
   endtask

   // drop valid and hold off until every predicted word has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_results.size() != 0) @(posedge clock);
   endtask

   task automatic set_idling(input int send_pct, input int stall_pct);
      send_idle_pct  = send_pct;
      recv_stall_pct = stall_pct;
   endtask

   function automatic logic [mhf_pkg::MAC_WIDTH-1:0] random_address();
      return {16'($urandom_range(16'hFFFF)), $urandom()};
   endfunction

   // field extremes, both commands, unsubscribe at zero and a bucket going back to empty
   task automatic test_directed();
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h0000_0000_0000);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h0000_0000_0000);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'hFFFF_FFFF_FFFF);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'hAAAA_AAAA_AAAA);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h5555_5555_5555);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h0100_5E00_0001);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h3333_0000_0001);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h0180_C200_0000);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h8000_0000_0000);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h0000_0000_0001);
      send_word(mhf_pkg::CMD_SUBSCRIBE,   48'h0000_0000_0000);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'hFFFF_FFFF_FFFF);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h0000_0000_0000);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h0000_0000_0000);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h0000_0000_0000);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'hAAAA_AAAA_AAAA);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h5555_5555_5555);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h8000_0000_0000);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h0100_5E00_0001);
      send_word(mhf_pkg::CMD_UNSUBSCRIBE, 48'h0100_5E00_0001);
   endtask

   // drive one bucket into saturation and then back down past zero
   task automatic test_count_saturation();
      logic [mhf_pkg::MAC_WIDTH-1:0] mac;
      mac = random_address();
      for (int i = 0; i <= int'(COUNT_FULL); i++) send_word(mhf_pkg::CMD_SUBSCRIBE, mac);
      send_word(mhf_pkg::CMD_SUBSCRIBE, mac);
      for (int i = 0; i <= int'(COUNT_FULL) + 1; i++)
         send_word(mhf_pkg::CMD_UNSUBSCRIBE, mac);
   endtask

   // mostly pooled addresses so counts climb and fall; some fresh addresses as noise
   task automatic test_random_traffic(input int count, input bit drain_midway);
      mhf_pkg::mhf_cmd_type          cmd;
      logic [mhf_pkg::MAC_WIDTH-1:0] mac;
      for (int i = 0; i < count; i++) begin
         if (drain_midway && i == count / 2) wait_for_drain();
         cmd = ($urandom_range(99) < 55) ? mhf_pkg::CMD_SUBSCRIBE : mhf_pkg::CMD_UNSUBSCRIBE;
         if ($urandom_range(99) < 80) mac = address_pool[5'($urandom_range(23))];
         else mac = random_address();
         send_word(cmd, mac);
      end
   endtask

   initial begin
      for (int i = 0; i < mhf_pkg::BUCKET_COUNT; i++) bucket_refs[i] = '0;
      subscribed_map = '0;
      for (int i = 0; i < 24; i++) address_pool[i] = random_address();

      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      set_idling(0, 0);
      test_directed();
      set_idling(22, 22);
      test_count_saturation();

      // random traffic through each idling mix
      set_idling(0, 0);
      test_random_traffic(220, 1'b0);
      set_idling(58, 0);
      test_random_traffic(220, 1'b1);
      set_idling(0, 58);
      test_random_traffic(220, 1'b0);
      set_idling(22, 22);
      test_random_traffic(220, 1'b0);

      wait_for_drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
